### hw/rtl/vfc_pkg.sv
// vfc_pkg: shared types, constants, face tables and the microcode ROM
// of the voxel face cull mesher. No dependencies.
package vfc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [5:0] SIZE_RESET = 6'd32;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] STEP_CLEAR     = 4'd0;
  localparam logic [PC_W-1:0] STEP_IDLE      = 4'd1;
  localparam logic [PC_W-1:0] STEP_RD_CTR    = 4'd2;
  localparam logic [PC_W-1:0] STEP_WRITE     = 4'd3;
  localparam logic [PC_W-1:0] STEP_CTR_CHK   = 4'd4;
  localparam logic [PC_W-1:0] STEP_NB_LOOP   = 4'd5;
  localparam logic [PC_W-1:0] STEP_EMIT_INIT = 4'd6;
  localparam logic [PC_W-1:0] STEP_EMIT      = 4'd7;
  localparam logic [PC_W-1:0] STEP_DONE      = 4'd8;

  localparam logic [2:0] FACE_LAST = 3'd5;
  localparam logic [2:0] FACE_NONE = 3'd6;
  localparam logic [2:0] VERT_LAST = 3'd5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_IDLE,
    OP_RD_CTR,
    OP_WRITE,
    OP_CTR_CHK,
    OP_NB_LOOP,
    OP_EMIT_INIT,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_CLR_BUSY,
    CND_NO_START,
    CND_MODE_RD,
    CND_CTR_OFF,
    CND_NB_MORE,
    CND_NONE_OPEN,
    CND_EMIT_MORE
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic mode_rd;
    logic nb_open;
    logic nb_more;
    logic none_open;
    logic emit_more;
  } stat_t;

  typedef struct packed {
    logic signed [6:0] dx;
    logic signed [6:0] dy;
    logic signed [6:0] dz;
  } dir_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      STEP_CLEAR:     w = '{OP_CLEAR,     CND_CLR_BUSY,  STEP_CLEAR};
      STEP_IDLE:      w = '{OP_IDLE,      CND_NO_START,  STEP_IDLE};
      STEP_RD_CTR:    w = '{OP_RD_CTR,    CND_MODE_RD,   STEP_CTR_CHK};
      STEP_WRITE:     w = '{OP_WRITE,     CND_ALWAYS,    STEP_IDLE};
      STEP_CTR_CHK:   w = '{OP_CTR_CHK,   CND_CTR_OFF,   STEP_IDLE};
      STEP_NB_LOOP:   w = '{OP_NB_LOOP,   CND_NB_MORE,   STEP_NB_LOOP};
      STEP_EMIT_INIT: w = '{OP_EMIT_INIT, CND_NONE_OPEN, STEP_IDLE};
      STEP_EMIT:      w = '{OP_EMIT,      CND_EMIT_MORE, STEP_EMIT};
      STEP_DONE:      w = '{OP_NOP,       CND_ALWAYS,    STEP_IDLE};
      default:        w = '{OP_NOP,       CND_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic dir_t face_dir(input logic [2:0] f);
    dir_t d;
    d = '{7'sd0, 7'sd0, 7'sd0};
    case (f)
      3'd0:    d.dy = 7'sd1;
      3'd1:    d.dy = -7'sd1;
      3'd2:    d.dx = 7'sd1;
      3'd3:    d.dx = -7'sd1;
      3'd4:    d.dz = 7'sd1;
      3'd5:    d.dz = -7'sd1;
      default: d = '{7'sd0, 7'sd0, 7'sd0};
    endcase
    return d;
  endfunction

  // corner mask: bit0 +x, bit1 +y, bit2 +z
  function automatic logic [2:0] corner_of(input logic [2:0] f, input logic [2:0] k);
    logic [17:0] row;
    case (f)
      3'd0:    row = {3'd3, 3'd7, 3'd2, 3'd7, 3'd6, 3'd2};
      3'd1:    row = {3'd5, 3'd1, 3'd0, 3'd4, 3'd5, 3'd0};
      3'd2:    row = {3'd5, 3'd7, 3'd1, 3'd7, 3'd3, 3'd1};
      3'd3:    row = {3'd6, 3'd4, 3'd0, 3'd2, 3'd6, 3'd0};
      3'd4:    row = {3'd7, 3'd5, 3'd4, 3'd6, 3'd7, 3'd4};
      3'd5:    row = {3'd1, 3'd3, 3'd0, 3'd3, 3'd2, 3'd0};
      default: row = '0;
    endcase
    case (k)
      3'd0:    return row[2:0];
      3'd1:    return row[5:3];
      3'd2:    return row[8:6];
      3'd3:    return row[11:9];
      3'd4:    return row[14:12];
      3'd5:    return row[17:15];
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [4:0] light_of(input logic [2:0] f);
    case (f)
      3'd0:    return 5'd20;
      3'd1:    return 5'd15;
      3'd2:    return 5'd19;
      3'd3:    return 5'd17;
      3'd4:    return 5'd18;
      3'd5:    return 5'd16;
      default: return 5'd0;
    endcase
  endfunction

endpackage

### hw/rtl/voxel_face_cull_mesher_unit.sv
// voxel_face_cull_mesher_unit: top level; size registers, sequencer, datapath.
// Depends on vfc_pkg, vfc_useq, vfc_datapath.
//
//   channel   dir  handshake           beat
//   request   in   start_i & !busy_o   mode, pos, visible, rgba
//   vertex    out  valid_o (strobe)    vert xyz, rgba, light, face, last
//   config    in   cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// Write request: after accept, busy_o stays high through STEP_RD_CTR and STEP_WRITE.
// Face request: stops at CTR_CHK if off or outside, at EMIT_INIT if fully enclosed.
// One vertex per cycle; the 7 grid reads are serial on one read port.
// After reset a clearing pass over all MAX_DIM^3 grid cells holds busy_o high.
// Vertices cannot be stalled; config writes are taken at any time.
module voxel_face_cull_mesher_unit import vfc_pkg::*; #(
  parameter int MAX_DIM = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  mode_i,
  input  logic [4:0]            pos_x_i,
  input  logic [4:0]            pos_y_i,
  input  logic [4:0]            pos_z_i,
  input  logic                  visible_in_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  input  logic [7:0]            alpha_in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  valid_o,
  output logic signed [6:0]     vert_x_o,
  output logic signed [6:0]     vert_y_o,
  output logic signed [6:0]     vert_z_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  output logic [7:0]            alpha_out_o,
  output logic [4:0]            light_o,
  output logic [2:0]            face_o,
  output logic                  last_o
);

  logic [5:0] size_x_q, size_y_q, size_z_q;
  op_e        op;
  stat_t      stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE_X: size_x_q <= cfg_wdata_i;
        CFG_SIZE_Y: size_y_q <= cfg_wdata_i;
        CFG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  vfc_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy_o)
  );

  vfc_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .start_i      (start_i),
    .mode_i       (mode_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .visible_in_i (visible_in_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .alpha_in_i   (alpha_in_i),
    .size_x_i     (size_x_q),
    .size_y_i     (size_y_q),
    .size_z_i     (size_z_q),
    .stat_o       (stat),
    .valid_o      (valid_o),
    .vert_x_o     (vert_x_o),
    .vert_y_o     (vert_y_o),
    .vert_z_o     (vert_z_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .alpha_out_o  (alpha_out_o),
    .light_o      (light_o),
    .face_o       (face_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  a_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("vertex beat outside a request");

  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o) else $error("gap inside a vertex run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> !valid_o) else $error("beat after last vertex");

  a_light_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (face_o <= FACE_LAST) && (light_o == light_of(face_o)))
    else $error("light does not match face");
`endif

endmodule

### hw/rtl/vfc_useq.sv
// vfc_useq: step counter, microcode fetch and jump condition select.
// Depends on vfc_pkg.
module vfc_useq import vfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output op_e   op_o,
  output logic  busy_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            take;

  assign word = ucode(pc_q);

  always_comb begin
    case (word.cond)
      CND_ALWAYS:    take = 1'b1;
      CND_CLR_BUSY:  take = !stat_i.clr_last;
      CND_NO_START:  take = !start_i;
      CND_MODE_RD:   take = stat_i.mode_rd;
      CND_CTR_OFF:   take = stat_i.nb_open;
      CND_NB_MORE:   take = stat_i.nb_more;
      CND_NONE_OPEN: take = stat_i.none_open;
      CND_EMIT_MORE: take = stat_i.emit_more;
      default:       take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o   = word.op;
  assign busy_o = (pc_q != STEP_IDLE);

endmodule

### hw/rtl/vfc_datapath.sv
// vfc_datapath: voxel stores, neighbor reads, face mask and vertex output.
// Depends on vfc_pkg; driven by the op from vfc_useq.
module vfc_datapath import vfc_pkg::*; #(
  parameter int MAX_DIM = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  op_e               op_i,
  input  logic              start_i,
  input  logic              mode_i,
  input  logic [4:0]        pos_x_i,
  input  logic [4:0]        pos_y_i,
  input  logic [4:0]        pos_z_i,
  input  logic              visible_in_i,
  input  logic [7:0]        red_in_i,
  input  logic [7:0]        green_in_i,
  input  logic [7:0]        blue_in_i,
  input  logic [7:0]        alpha_in_i,
  input  logic [5:0]        size_x_i,
  input  logic [5:0]        size_y_i,
  input  logic [5:0]        size_z_i,
  output stat_t             stat_o,
  output logic              valid_o,
  output logic signed [6:0] vert_x_o,
  output logic signed [6:0] vert_y_o,
  output logic signed [6:0] vert_z_o,
  output logic [7:0]        red_out_o,
  output logic [7:0]        green_out_o,
  output logic [7:0]        blue_out_o,
  output logic [7:0]        alpha_out_o,
  output logic [4:0]        light_o,
  output logic [2:0]        face_o,
  output logic              last_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(DEPTH);
  localparam logic [9:0] MaxDimW = 10'(MAX_DIM);
  localparam logic [AW-1:0] ClrEnd = AW'(DEPTH - 1);

  logic        vis_mem [DEPTH];
  logic [31:0] col_mem [DEPTH];

  logic          mode_q, vis_q;
  logic [4:0]    px_q, py_q, pz_q;
  logic [31:0]   col_q;
  logic [AW-1:0] clr_q;
  logic          rd_vis_q, rd_ok_q;
  logic [31:0]   rd_col_q;
  logic [5:0]    open_q;
  logic [2:0]    fc_q, k_q;

  logic              accept;
  logic [2:0]        fsel;
  dir_t              d;
  logic signed [6:0] nx, ny, nz;
  logic              nb_ok, wr_ok, wr_en, nb_open;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [5:0]        mask_hi;
  logic              vert_last;
  logic [2:0]        cm;

  function automatic logic coord_ok(input logic signed [6:0] n, input logic [5:0] lim);
    return (n >= 7'sd0) && (n[5:0] < lim) && ({4'b0, n[5:0]} < MaxDimW);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [5:0] x, input logic [5:0] y,
                                            input logic [5:0] z);
    return AW'((AW'(y) * AW'(MAX_DIM) + AW'(z)) * AW'(MAX_DIM) + AW'(x));
  endfunction

  function automatic logic [2:0] low_idx(input logic [5:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    return r;
  endfunction

  assign accept = (op_i == OP_IDLE) && start_i;

  always_comb begin
    case (op_i)
      OP_CTR_CHK: fsel = 3'd0;
      OP_NB_LOOP: fsel = fc_q + 3'd1;
      default:    fsel = FACE_NONE;
    endcase
  end

  assign d       = face_dir(fsel);
  assign nx      = $signed({2'b00, px_q}) + d.dx;
  assign ny      = $signed({2'b00, py_q}) + d.dy;
  assign nz      = $signed({2'b00, pz_q}) + d.dz;
  assign nb_ok   = coord_ok(nx, size_x_i) && coord_ok(ny, size_y_i) && coord_ok(nz, size_z_i);
  assign rd_addr = addr_of(nx[5:0], ny[5:0], nz[5:0]);

  assign wr_ok   = ({5'b0, px_q} < MaxDimW) && ({5'b0, py_q} < MaxDimW) &&
                   ({5'b0, pz_q} < MaxDimW);
  assign wr_en   = (op_i == OP_CLEAR) || ((op_i == OP_WRITE) && wr_ok);
  assign wr_addr = (op_i == OP_CLEAR) ? clr_q
                                      : addr_of({1'b0, px_q}, {1'b0, py_q}, {1'b0, pz_q});

  assign nb_open   = !(rd_ok_q && rd_vis_q);
  assign mask_hi   = open_q & (6'b111111 << (fc_q + 3'd1));
  assign vert_last = (k_q == VERT_LAST) && (mask_hi == 6'd0);
  assign cm        = corner_of(fc_q, k_q);

  assign stat_o.clr_last  = (clr_q == ClrEnd);
  assign stat_o.mode_rd   = mode_q;
  assign stat_o.nb_open   = nb_open;
  assign stat_o.nb_more   = (fc_q != FACE_LAST);
  assign stat_o.none_open = (open_q == 6'd0);
  assign stat_o.emit_more = !vert_last;

  always_ff @(posedge clk_i) begin
    if (wr_en) vis_mem[wr_addr] <= (op_i == OP_WRITE) && vis_q;
    if ((op_i == OP_WRITE) && wr_ok) col_mem[wr_addr] <= col_q;
    rd_vis_q <= vis_mem[rd_addr];
    rd_col_q <= col_mem[rd_addr];
    rd_ok_q  <= nb_ok;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      vis_q  <= visible_in_i;
      col_q  <= {alpha_in_i, blue_in_i, green_in_i, red_in_i};
    end else if (op_i == OP_CTR_CHK) begin
      col_q <= rd_col_q;
    end
    if (op_i == OP_EMIT) begin
      vert_x_o    <= $signed({1'b0, px_q, 1'b0} + (cm[0] ? 7'd1 : 7'h7F));
      vert_y_o    <= $signed({1'b0, py_q, 1'b0} + (cm[1] ? 7'd1 : 7'h7F));
      vert_z_o    <= $signed({1'b0, pz_q, 1'b0} + (cm[2] ? 7'd1 : 7'h7F));
      red_out_o   <= col_q[7:0];
      green_out_o <= col_q[15:8];
      blue_out_o  <= col_q[23:16];
      alpha_out_o <= col_q[31:24];
      light_o     <= light_of(fc_q);
      face_o      <= fc_q;
      last_o      <= vert_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      open_q  <= '0;
      fc_q    <= '0;
      k_q     <= '0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= (op_i == OP_EMIT);
      case (op_i)
        OP_CLEAR: clr_q <= clr_q + AW'(1);
        OP_CTR_CHK: fc_q <= 3'd0;
        OP_NB_LOOP: begin
          open_q[fc_q] <= nb_open;
          fc_q         <= fc_q + 3'd1;
        end
        OP_EMIT_INIT: begin
          fc_q <= low_idx(open_q);
          k_q  <= 3'd0;
        end
        OP_EMIT: begin
          if (k_q == VERT_LAST) begin
            fc_q <= low_idx(mask_hi);
            k_q  <= 3'd0;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
